>>> hw/rtl/rotenc_pkg.sv
// Shared types and constants for the rotary encoder turn detector.
// No dependencies; imported by every module of the block.
package rotenc_pkg;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } step_dir_t;

  localparam int unsigned AddrWidth = 3;

  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [15:0] TimeoutReset   = 16'd500;
  localparam logic [6:0]  ThresholdReset = 7'd5;
  localparam logic [15:0] IdleMax        = 16'hFFFF;

  typedef struct packed {
    logic [15:0] timeout;
    logic [6:0]  threshold;
  } rotenc_cfg_t;

  typedef struct packed {
    logic signed [31:0] position;
    step_dir_t          step_dir;
    logic               right_turn;
    logic               left_turn;
    logic signed [7:0]  turn_progress;
  } rotenc_result_t;

endpackage

>>> hw/rtl/rotenc_if.sv
// Valid/ready channel interfaces for pin samples and decoded results.
// No dependencies.
interface rotenc_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

interface rotenc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic [1:0]         step_dir;
  logic               right_turn;
  logic               left_turn;
  logic signed [7:0]  turn_progress;

  modport source (output valid, output position, output step_dir, output right_turn,
                  output left_turn, output turn_progress, input ready);
  modport sink   (input valid, input position, input step_dir, input right_turn,
                  input left_turn, input turn_progress, output ready);
endinterface

>>> hw/rtl/rotenc_step.sv
// Quadrature step decoder with partial turn counter and idle timer.
// Depends on rotenc_pkg.
module rotenc_step
  import rotenc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           pin_a,
  input  logic           pin_b,
  input  rotenc_cfg_t    cfg,
  output rotenc_result_t res
);

  logic               prev_a;
  logic               armed;
  logic               saved_b;
  logic signed [31:0] position;
  logic signed [7:0]  partial;
  logic [15:0]        idle;

  logic [15:0]        idle_next;
  logic               rise;
  logic               fall;
  step_dir_t          dir;
  logic signed [7:0]  base;
  logic signed [7:0]  up;
  logic signed [7:0]  down;
  logic signed [8:0]  thr_pos;
  logic signed [8:0]  thr_neg;
  logic               right;
  logic               left;
  logic signed [31:0] position_next;
  logic signed [7:0]  partial_next;

  always_comb begin
    idle_next = (idle == IdleMax) ? idle : idle + 16'd1;
    rise      = pin_a & ~prev_a;
    fall      = ~pin_a & prev_a & armed;
    if (fall && !pin_b && saved_b) begin
      dir = DIR_CW;
    end else if (fall && pin_b && !saved_b) begin
      dir = DIR_CCW;
    end else begin
      dir = DIR_NONE;
    end
    base    = (idle_next > cfg.timeout) ? 8'sd0 : partial;
    up      = base + 8'sd1;
    down    = base - 8'sd1;
    thr_pos = $signed({2'b00, cfg.threshold});
    thr_neg = -thr_pos;
    right   = (dir == DIR_CW) && ($signed({up[7], up}) >= thr_pos);
    left    = (dir == DIR_CCW) && ($signed({down[7], down}) <= thr_neg);

    position_next = position;
    partial_next  = partial;
    unique case (dir)
      DIR_CW: begin
        position_next = position + 32'sd1;
        partial_next  = right ? 8'sd0 : up;
      end
      DIR_CCW: begin
        position_next = position - 32'sd1;
        partial_next  = left ? 8'sd0 : down;
      end
      default: begin
        position_next = position;
        partial_next  = partial;
      end
    endcase

    res.position      = position_next;
    res.step_dir      = dir;
    res.right_turn    = right;
    res.left_turn     = left;
    res.turn_progress = partial_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a   <= 1'b0;
      armed    <= 1'b0;
      saved_b  <= 1'b0;
      position <= '0;
      partial  <= '0;
      idle     <= '0;
    end else if (en) begin
      prev_a   <= pin_a;
      position <= position_next;
      partial  <= partial_next;
      idle     <= (dir == DIR_NONE) ? idle_next : 16'd0;
      if (rise) begin
        saved_b <= pin_b;
        armed   <= 1'b1;
      end else if (fall) begin
        armed <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/rotary_encoder_turn_detector_top.sv
// Rotary encoder turn detector: top level with APB registers and channel pipeline.
// Depends on rotenc_pkg, rotenc_if and rotenc_step.
//
// Usage: one beat on the sample channel carries one tick's sample of encoder pins
// A and B. Each sample yields exactly one beat on the result channel with the step
// position, step direction, turn pulses and the partial turn count.
// Path: an accepted sample passes through the input register, then the result
// register fed by the decoder, before it is presented on the result channel.
// Throughput: one sample per cycle while the result channel does not stall; the
// decoder state updates in the same cycle the sample leaves the input register.
// Stall: while the result beat waits, the input register still takes one more
// sample; the sample channel then holds ready low until the result is taken.
// Reset (rst, synchronous): both pipeline stages empty, decoder state cleared,
// timeout = 500 ticks and threshold = 5 steps.
// Registers: 0x0 timeout (16 bit), 0x4 threshold (7 bit). Write them only when the
// pipeline is drained. pready is always high.
module rotary_encoder_turn_detector_top
  import rotenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  rotenc_in_if.sink            sample,
  rotenc_out_if.source         result
);

  rotenc_cfg_t    cfg;
  logic           cfg_wr;
  logic           s1_valid;
  logic           s1_a;
  logic           s1_b;
  logic           out_valid;
  rotenc_result_t out_data;
  rotenc_result_t step_res;
  logic           advance;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout   <= TimeoutReset;
      cfg.threshold <= ThresholdReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TIMEOUT:   cfg.timeout   <= pwdata[15:0];
        REG_THRESHOLD: cfg.threshold <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT:   prdata = {16'd0, cfg.timeout};
      REG_THRESHOLD: prdata = {25'd0, cfg.threshold};
      default:       prdata = '0;
    endcase
  end

  assign advance      = ~out_valid | result.ready;
  assign sample.ready = ~s1_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_a <= sample.pin_a;
      s1_b <= sample.pin_b;
    end
  end

  rotenc_step u_step (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_valid & advance),
    .pin_a (s1_a),
    .pin_b (s1_b),
    .cfg   (cfg),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.position      = out_data.position;
  assign result.step_dir      = out_data.step_dir;
  assign result.right_turn    = out_data.right_turn;
  assign result.left_turn     = out_data.left_turn;
  assign result.turn_progress = out_data.turn_progress;

endmodule

>>> hw/rtl/rotenc_checker.sv
// Port-level checks on the result channel of the turn detector, bound to the top.
// Depends on rotenc_pkg and rotary_encoder_turn_detector_top.
module rotenc_checker
  import rotenc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic signed [31:0] position,
  input logic [1:0]        step_dir,
  input logic              right_turn,
  input logic              left_turn,
  input logic signed [7:0] turn_progress
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result beat valid right after reset");

  a_pulse_cw: assert property (@(posedge clk) disable iff (rst)
    valid && right_turn |-> step_dir == DIR_CW && turn_progress == 8'sd0)
    else $error("right turn without clockwise step or nonzero progress");

  a_pulse_ccw: assert property (@(posedge clk) disable iff (rst)
    valid && left_turn |-> step_dir == DIR_CCW && turn_progress == 8'sd0)
    else $error("left turn without counterclockwise step or nonzero progress");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(position) && $stable(step_dir)
      && $stable(turn_progress))
    else $error("stalled result beat changed");

endmodule

bind rotary_encoder_turn_detector_top rotenc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .position      (result.position),
  .step_dir      (result.step_dir),
  .right_turn    (result.right_turn),
  .left_turn     (result.left_turn),
  .turn_progress (result.turn_progress)
);

>>> tb/tb_rotary_encoder_turn_detector_top.sv
// Self-checking testbench for rotary_encoder_turn_detector_top: directed table, idle
// timeout run and randomized quadrature sequences, checked beat by beat against a decoder model.
// Depends on rotenc_pkg, rotenc_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_rotary_encoder_turn_detector_top;
  import rotenc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic           pin_a;
    logic           pin_b;
    logic           typed;
    rotenc_result_t want;
  } directed_row_t;

  localparam directed_row_t DIRECTED [27] = '{
    '{1'b0, 1'b0, 1'b1, '{32'sd0, DIR_NONE, 1'b0, 1'b0, 8'sd0}},
    '{1'b1, 1'b1, 1'b1, '{32'sd0, DIR_NONE, 1'b0, 1'b0, 8'sd0}},
    '{1'b0, 1'b0, 1'b1, '{32'sd1, DIR_CW,   1'b0, 1'b0, 8'sd1}},
    '{1'b1, 1'b0, 1'b1, '{32'sd1, DIR_NONE, 1'b0, 1'b0, 8'sd1}},
    '{1'b0, 1'b1, 1'b1, '{32'sd0, DIR_CCW,  1'b0, 1'b0, 8'sd0}},
    '{1'b1, 1'b0, 1'b0, '0},
    // falling edge with B unchanged: no step
    '{1'b0, 1'b0, 1'b1, '{32'sd0, DIR_NONE, 1'b0, 1'b0, 8'sd0}},
    '{1'b1, 1'b1, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, '{32'sd5, DIR_CW,   1'b1, 1'b0, 8'sd0}},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b1, '{32'sd0, DIR_CCW,  1'b0, 1'b1, 8'sd0}}
  };

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  rotenc_in_if  sample_ch ();
  rotenc_out_if result_ch ();

  rotary_encoder_turn_detector_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // decoder model state
  logic [15:0]        cfg_timeout   = TimeoutReset;
  logic [6:0]         cfg_threshold = ThresholdReset;
  logic               enc_prev_a    = 1'b0;
  logic               enc_armed     = 1'b0;
  logic               enc_saved_b   = 1'b0;
  logic signed [31:0] enc_position  = '0;
  int                 enc_partial   = 0;
  logic [15:0]        enc_idle      = '0;

  rotenc_result_t pending_results [$];
  int mismatches    = 0;
  int samples_sent  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rotenc_result_t decode_sample(input logic a, input logic b);
    rotenc_result_t r;
    step_dir_t      dir;
    r   = '0;
    dir = DIR_NONE;
    if (enc_idle != IdleMax) enc_idle++;
    if (a && !enc_prev_a) begin
      enc_saved_b = b;
      enc_armed   = 1'b1;
    end else if (!a && enc_prev_a && enc_armed) begin
      if (!b && enc_saved_b) dir = DIR_CW;
      else if (b && !enc_saved_b) dir = DIR_CCW;
      enc_armed = 1'b0;
    end
    enc_prev_a = a;
    if (dir != DIR_NONE) begin
      if (enc_idle > cfg_timeout) enc_partial = 0;
      if (dir == DIR_CW) begin
        enc_position++;
        enc_partial++;
        if (enc_partial >= int'(cfg_threshold)) begin
          r.right_turn = 1'b1;
          enc_partial  = 0;
        end
      end else begin
        enc_position--;
        enc_partial--;
        if (enc_partial <= -int'(cfg_threshold)) begin
          r.left_turn = 1'b1;
          enc_partial = 0;
        end
      end
      enc_idle = '0;
    end
    r.position      = enc_position;
    r.step_dir      = dir;
    r.turn_progress = enc_partial[7:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    rotenc_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, got position %0d",
                 $time, result_ch.position);
      end else begin
        want = pending_results.pop_front();
        check_field("position", want.position, result_ch.position);
        check_field("step_dir", want.step_dir, result_ch.step_dir);
        check_field("right_turn", want.right_turn, result_ch.right_turn);
        check_field("left_turn", want.left_turn, result_ch.left_turn);
        check_field("turn_progress", want.turn_progress, result_ch.turn_progress);
      end
    end
  end

  task automatic send_sample(input logic a, input logic b, input logic typed = 1'b0,
                             input rotenc_result_t want = '0);
    rotenc_result_t predicted;
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.pin_a <= a;
    sample_ch.pin_b <= b;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
    predicted = decode_sample(a, b);
    pending_results.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // back-to-back APB writes: timeout, then threshold
  task automatic set_config(input logic [15:0] timeout, input logic [6:0] threshold);
    for (int i = 0; i < 2; i++) begin
      if (i == 0) begin
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {REG_TIMEOUT, 2'b00};
        pwdata <= {16'd0, timeout};
      end else begin
        paddr  <= {REG_THRESHOLD, 2'b00};
        pwdata <= {25'd0, threshold};
      end
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
    end
    psel          <= 1'b0;
    penable       <= 1'b0;
    cfg_timeout   = timeout;
    cfg_threshold = threshold;
  endtask

  function automatic int hold_len();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
  endfunction

  task automatic play_gesture();
    int   pick;
    int   cap;
    int   steps;
    logic b0;
    pick  = int'($urandom_range(0, 99));
    b0    = 1'($urandom_range(0, 1));
    steps = (int'(cfg_threshold) + 2 < 12) ? int'(cfg_threshold) + 2 : 12;
    if (pick < 70) begin
      // a run of well-formed steps in one direction
      repeat ($urandom_range(1, steps)) begin
        repeat (1 + hold_len()) send_sample(1'b1, b0);
        repeat (1 + hold_len()) send_sample(1'b0, !b0);
      end
    end else if (pick < 80) begin
      cap = (cfg_timeout < 16'd64) ? int'(cfg_timeout) + 3 : 10;
      repeat ($urandom_range(0, cap)) send_sample(1'b0, 1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      send_sample(1'b1, b0);
      send_sample(1'b0, b0);
    end else begin
      repeat ($urandom_range(1, 4))
        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input logic [15:0] timeout, input logic [6:0] threshold,
                           input int idle_pct, input int stall, input int count);
    int start;
    drain();
    set_config(timeout, threshold);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    start         = samples_sent;
    while (samples_sent - start < count) play_gesture();
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sample_ch.valid = 1'b0;
    sample_ch.pin_a = 1'b0;
    sample_ch.pin_b = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_sample(DIRECTED[i].pin_a, DIRECTED[i].pin_b, DIRECTED[i].typed, DIRECTED[i].want);
    drain();

    // idle gap past the timeout clears the partial count on the next step
    set_config(16'd10, 7'd127);
    repeat (3) begin
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
    end
    repeat (12) send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);

    run_phase(16'd500, 7'd5, 0, 0, 40);
    run_phase(16'd0, 7'd4, 67, 0, 40);
    run_phase(16'hFFFF, 7'd127, 0, 67, 40);
    run_phase(16'd3, 7'd0, 22, 22, 40);
    run_phase(16'd20, 7'd1, 67, 0, 40);
    run_phase(16'd8, 7'd3, 0, 0, 40);
    run_phase(16'($urandom_range(0, 40)), 7'($urandom_range(1, 8)), 0, 67, 40);
    run_phase(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)), 22, 22, 40);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
